[rtl/core/uges_pkg.sv]
// ----------------------------------------------------------------------------
// uges_pkg
// Shared types and constants of the undirected graph edge store.
// ----------------------------------------------------------------------------
package uges_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_MAX_EDGES    = 32;

    // input action codes
    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_QUERY  = 3'd2;
    localparam logic [2:0] ACT_NBR    = 3'd3;
    localparam logic [2:0] ACT_EDGES  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam int RESULT_CAP  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam logic [3:0] LAST_PASS = 4'hF;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_BAD,
        OP_QUERY,
        OP_NBR,
        OP_EDGES
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] a;
        logic [3:0] b;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } t_bstate;

    typedef struct packed {
        logic [1:0] status;
        logic       adjacent;
        logic       has_item;
        logic [3:0] first_vertex;
        logic [3:0] second_vertex;
        logic [5:0] edge_total;
        logic       last;
    } t_result;

endpackage

[rtl/core/uges_front.sv]
// ----------------------------------------------------------------------------
// uges_front
// Accepts input items, checks vertices against the vertex count and queues
// classified commands for the back end.
// ----------------------------------------------------------------------------
module uges_front
    import uges_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_action,
    input  logic [3:0] i_vertex_a,
    input  logic [3:0] i_vertex_b,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    localparam int NV_RST = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;

    logic [4:0]    r_num_vertices;
    t_cmd          r_queue [QUEUE_DEPTH];
    logic [QW-1:0] r_wr_ptr;
    logic [QW-1:0] r_rd_ptr;
    logic [QW:0]   r_fill;

    logic a_ok;
    logic b_ok;
    logic push;
    t_cmd cmd;

    // vertex must lie below both the register and the build limit
    assign a_ok = (5'(i_vertex_a) < r_num_vertices) &&
                  ({28'd0, i_vertex_a} < 32'(MAX_VERTICES));
    assign b_ok = (5'(i_vertex_b) < r_num_vertices) &&
                  ({28'd0, i_vertex_b} < 32'(MAX_VERTICES));

    always_comb begin
        cmd.a = i_vertex_a;
        cmd.b = i_vertex_b;
        case (i_action)
            ACT_CLEAR:  cmd.op = OP_CLEAR;
            ACT_INSERT: cmd.op = (a_ok && b_ok && (i_vertex_a != i_vertex_b)) ?
                                 OP_INSERT : OP_BAD;
            ACT_QUERY:  cmd.op = (a_ok && b_ok) ? OP_QUERY : OP_BAD;
            ACT_NBR:    cmd.op = a_ok ? OP_NBR : OP_BAD;
            ACT_EDGES:  cmd.op = OP_EDGES;
            default:    cmd.op = OP_BAD;
        endcase
    end

    assign o_in_stall  = (r_fill == (QW+1)'(QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= 5'(NV_RST);
        end else if (i_cfg_we) begin
            r_num_vertices <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !i_cmd_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!push && i_cmd_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

[rtl/core/uges_back.sv]
// ----------------------------------------------------------------------------
// uges_back
// Executes queued commands on the edge log: updates, adjacency scans and
// listings, and holds the result in an output register.
// ----------------------------------------------------------------------------
module uges_back
    import uges_pkg::*;
#(
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    t_bstate       r_state;
    t_bstate       n_state;
    t_cmd          r_cmd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_log [MAX_EDGES];
    logic [AW-1:0] r_idx;
    logic          r_more;
    logic          r_rd_vld;
    logic [7:0]    r_rd_data;
    logic [3:0]    r_pass;
    logic          r_hit;
    logic          r_hold_vld;
    logic [3:0]    r_hold_f;
    logic [3:0]    r_hold_s;
    logic [5:0]    r_cnt;
    logic          r_out_vld;
    t_result       r_out;

    logic       out_free;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] lo;
    logic [3:0] hi;
    logic       match;
    logic [3:0] m_first;
    logic [3:0] m_second;
    logic       take;
    logic       stall_eval;
    logic       advance;
    logic       pass_end;
    logic       more_passes;
    logic       is_scan_op;
    logic       push;
    logic       we;
    t_result    res;

    assign out_free = !r_out_vld || !i_out_stall;

    assign x  = r_rd_data[3:0];
    assign y  = r_rd_data[7:4];
    assign lo = (x < y) ? x : y;
    assign hi = (x < y) ? y : x;

    always_comb begin
        match    = 1'b0;
        m_first  = '0;
        m_second = '0;
        case (r_cmd.op)
            OP_NBR: begin
                match    = (x == r_cmd.a) || (y == r_cmd.a);
                m_first  = r_cmd.a;
                m_second = (x == r_cmd.a) ? y : x;
            end
            OP_EDGES: begin
                match    = (lo == r_pass);
                m_first  = lo;
                m_second = hi;
            end
            default: begin
                match = 1'b0;
            end
        endcase
    end

    // results past the cap are dropped, the scan still runs to its end
    assign take        = r_rd_vld && match && (r_cnt < 6'(RESULT_CAP));
    assign stall_eval  = take && r_hold_vld && !out_free;
    assign advance     = (r_state == B_SCAN) && !stall_eval;
    assign pass_end    = (r_state == B_SCAN) && !r_more && !r_rd_vld;
    assign more_passes = (r_cmd.op == OP_EDGES) && (r_pass != LAST_PASS);
    assign is_scan_op  = (i_cmd.op == OP_QUERY) || (i_cmd.op == OP_NBR) ||
                         (i_cmd.op == OP_EDGES);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid && is_scan_op) begin
                    n_state = B_SCAN;
                end
            end
            B_SCAN: begin
                if (pass_end && !more_passes) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_cmd_pop = 1'b0;
        push      = 1'b0;
        we        = 1'b0;
        n_count   = r_count;
        res       = '0;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    if (is_scan_op) begin
                        o_cmd_pop = 1'b1;
                    end else if (out_free) begin
                        o_cmd_pop = 1'b1;
                        push      = 1'b1;
                        res.last  = 1'b1;
                        case (i_cmd.op)
                            OP_CLEAR: begin
                                n_count    = '0;
                                res.status = ST_OK;
                            end
                            OP_INSERT: begin
                                if (r_count >= CW'(MAX_EDGES)) begin
                                    res.status = ST_FULL;
                                end else begin
                                    we         = 1'b1;
                                    n_count    = r_count + 1'b1;
                                    res.status = ST_OK;
                                end
                            end
                            default: res.status = ST_INVALID;
                        endcase
                        res.edge_total = 6'(n_count);
                    end
                end
            end
            B_SCAN: begin
                // a new match pushes out the one held before it
                if (take && r_hold_vld && out_free) begin
                    push               = 1'b1;
                    res.status         = ST_OK;
                    res.has_item       = 1'b1;
                    res.first_vertex   = r_hold_f;
                    res.second_vertex  = r_hold_s;
                    res.edge_total     = 6'(r_count);
                end
            end
            B_DONE: begin
                if (out_free) begin
                    push              = 1'b1;
                    res.status        = ST_OK;
                    res.adjacent      = r_hit;
                    res.has_item      = r_hold_vld;
                    res.first_vertex  = r_hold_vld ? r_hold_f : 4'd0;
                    res.second_vertex = r_hold_vld ? r_hold_s : 4'd0;
                    res.edge_total    = 6'(r_count);
                    res.last          = 1'b1;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    // edge log
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_log[r_count[AW-1:0]] <= {i_cmd.b, i_cmd.a};
        end
        if (advance && r_more) begin
            r_rd_data <= r_log[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
            r_more     <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_cnt      <= '0;
            r_hit      <= 1'b0;
            r_pass     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            if (r_state == B_IDLE && i_cmd_valid && is_scan_op) begin
                r_cmd      <= i_cmd;
                r_idx      <= AW'(r_count - 1'b1);
                r_more     <= (r_count != '0);
                r_rd_vld   <= 1'b0;
                r_pass     <= '0;
                r_hit      <= 1'b0;
                r_hold_vld <= 1'b0;
                r_cnt      <= '0;
            end else if (pass_end && more_passes) begin
                r_pass <= r_pass + 1'b1;
                r_idx  <= AW'(r_count - 1'b1);
                r_more <= (r_count != '0);
            end else if (advance) begin
                r_rd_vld <= r_more;
                if (r_more) begin
                    if (r_idx == '0) begin
                        r_more <= 1'b0;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                if (r_rd_vld && (r_cmd.op == OP_QUERY) &&
                    (((x == r_cmd.a) && (y == r_cmd.b)) ||
                     ((x == r_cmd.b) && (y == r_cmd.a)))) begin
                    r_hit <= 1'b1;
                end
                if (take) begin
                    r_hold_vld <= 1'b1;
                    r_hold_f   <= m_first;
                    r_hold_s   <= m_second;
                    r_cnt      <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule

[rtl/core/undirected_graph_edge_store_top.sv]
// ----------------------------------------------------------------------------
// undirected_graph_edge_store_top
// Undirected multigraph kept as an insertion-ordered edge log, with insert,
// clear, adjacency query, neighbor listing and edge listing.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      i_in_valid/o_in_stall  action, vertex_a, vertex_b
//  out       output     o_out_valid/i_out_stall status .. last, one per result
//  cfg       input      i_cfg_we               i_cfg_wdata (num_vertices)
//
//  clear, insert and rejected items: answered from the executor's idle state
//  query and neighbor listing: one scan of the log, newest entry first
//  edge listing: a scan of the log for each pass;
//  one log entry a cycle unless the scan is held, one pass per low vertex
//  reset zeroes the edge count; the log itself is not cleared
//  an output stall holds the scan when a match meets a result ready to leave
// ----------------------------------------------------------------------------
module undirected_graph_edge_store_top
    import uges_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_action,
    input  logic [3:0] i_vertex_a,
    input  logic [3:0] i_vertex_b,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic       o_adjacent,
    output logic       o_has_item,
    output logic [3:0] o_first_vertex,
    output logic [3:0] o_second_vertex,
    output logic [5:0] o_edge_total,
    output logic       o_last
);

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    t_result result;

    uges_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    uges_back #(
        .MAX_EDGES (MAX_EDGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_status        = result.status;
    assign o_adjacent      = result.adjacent;
    assign o_has_item      = result.has_item;
    assign o_first_vertex  = result.first_vertex;
    assign o_second_vertex = result.second_vertex;
    assign o_edge_total    = result.edge_total;
    assign o_last          = result.last;

endmodule

[sim/tb_undirected_graph_edge_store_top.sv]
// ----------------------------------------------------------------------------
// tb_undirected_graph_edge_store_top
// Self-checking bench for the graph edge store. A behavioral copy of the edge
// log predicts every result of each accepted action; an output monitor checks
// the results in order. Directed cases, a capacity run, a sweep of the vertex
// count register and random traffic with stalls on both channels.
// ----------------------------------------------------------------------------
module tb_undirected_graph_edge_store_top;
    import uges_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 32;
    localparam int MAX_SHOWN     = 10;

    // action codes the block rejects
    localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
    localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [4:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [2:0] i_action;
    logic [3:0] i_vertex_a;
    logic [3:0] i_vertex_b;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_status;
    logic       o_adjacent;
    logic       o_has_item;
    logic [3:0] o_first_vertex;
    logic [3:0] o_second_vertex;
    logic [5:0] o_edge_total;
    logic       o_last;

    undirected_graph_edge_store_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_vertex_a      (i_vertex_a),
        .i_vertex_b      (i_vertex_b),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_adjacent      (o_adjacent),
        .o_has_item      (o_has_item),
        .o_first_vertex  (o_first_vertex),
        .o_second_vertex (o_second_vertex),
        .o_edge_total    (o_edge_total),
        .o_last          (o_last)
    );

    // behavioral copy of the graph
    logic [3:0] log_first  [DEF_MAX_EDGES];
    logic [3:0] log_second [DEF_MAX_EDGES];
    int         stored_edges;
    logic [4:0] vertex_count;

    t_result awaited_results [$];
    int      mismatches;
    int      cycle_count;
    bit      in_idle_en;
    bit      out_idle_en;
    int      out_stall_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int vertex_bound();
        return (vertex_count > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : int'(vertex_count);
    endfunction

    function automatic int add_result(int k, logic [1:0] st, logic adj, logic has,
                                      logic [3:0] fv, logic [3:0] sv);
        t_result r;
        if (k >= RESULT_CAP) return k;
        r.status        = st;
        r.adjacent      = adj;
        r.has_item      = has;
        r.first_vertex  = fv;
        r.second_vertex = sv;
        r.edge_total    = 6'(stored_edges);
        r.last          = 1'b0;
        awaited_results.push_back(r);
        return k + 1;
    endfunction

    // updates the graph copy and queues every result of one accepted action
    function automatic void apply_graph_action(logic [2:0] act, logic [3:0] va,
                                               logic [3:0] vb);
        int         bound;
        int         k;
        logic       hit;
        logic [3:0] lo;
        logic [3:0] hi;
        t_result    tail;
        bound = vertex_bound();
        k     = 0;
        hit   = 1'b0;
        case (act)
            ACT_CLEAR: begin
                stored_edges = 0;
                k = add_result(k, ST_OK, 1'b0, 1'b0, 4'd0, 4'd0);
            end
            ACT_INSERT: begin
                if (va >= bound || vb >= bound || va == vb) begin
                    k = add_result(k, ST_INVALID, 1'b0, 1'b0, 4'd0, 4'd0);
                end else if (stored_edges >= DEF_MAX_EDGES) begin
                    k = add_result(k, ST_FULL, 1'b0, 1'b0, 4'd0, 4'd0);
                end else begin
                    log_first[stored_edges]  = va;
                    log_second[stored_edges] = vb;
                    stored_edges++;
                    k = add_result(k, ST_OK, 1'b0, 1'b0, 4'd0, 4'd0);
                end
            end
            ACT_QUERY: begin
                if (va >= bound || vb >= bound) begin
                    k = add_result(k, ST_INVALID, 1'b0, 1'b0, 4'd0, 4'd0);
                end else begin
                    for (int i = 0; i < stored_edges; i++) begin
                        if ((log_first[i] == va && log_second[i] == vb) ||
                            (log_first[i] == vb && log_second[i] == va)) hit = 1'b1;
                    end
                    k = add_result(k, ST_OK, hit, 1'b0, 4'd0, 4'd0);
                end
            end
            ACT_NBR: begin
                if (va >= bound) begin
                    k = add_result(k, ST_INVALID, 1'b0, 1'b0, 4'd0, 4'd0);
                end else begin
                    for (int i = stored_edges - 1; i >= 0; i--) begin
                        if (log_first[i] == va)
                            k = add_result(k, ST_OK, 1'b0, 1'b1, va, log_second[i]);
                        else if (log_second[i] == va)
                            k = add_result(k, ST_OK, 1'b0, 1'b1, va, log_first[i]);
                    end
                    if (k == 0) k = add_result(k, ST_OK, 1'b0, 1'b0, 4'd0, 4'd0);
                end
            end
            ACT_EDGES: begin
                // all stored edges, whatever the current vertex count
                for (int v = 0; v < 16; v++) begin
                    for (int i = stored_edges - 1; i >= 0; i--) begin
                        lo = (log_first[i] < log_second[i]) ? log_first[i] : log_second[i];
                        hi = (log_first[i] < log_second[i]) ? log_second[i] : log_first[i];
                        if (lo == 4'(v)) k = add_result(k, ST_OK, 1'b0, 1'b1, lo, hi);
                    end
                end
                if (k == 0) k = add_result(k, ST_OK, 1'b0, 1'b0, 4'd0, 4'd0);
            end
            default: begin
                k = add_result(k, ST_INVALID, 1'b0, 1'b0, 4'd0, 4'd0);
            end
        endcase
        tail      = awaited_results.pop_back();
        tail.last = 1'b1;
        awaited_results.push_back(tail);
    endfunction

    // output side: random stall bursts and in-order checking of each transfer
    always @(posedge i_clk) begin : out_side
        t_result want;
        bit      bad;
        if (!i_rst_n) begin
            i_out_stall    <= 1'b0;
            out_stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result: st=%0d adj=%0b has=%0b %0d-%0d tot=%0d last=%0b",
                                 o_status, o_adjacent, o_has_item, o_first_vertex,
                                 o_second_vertex, o_edge_total, o_last);
                end else begin
                    want = awaited_results.pop_front();
                    bad  = 1'b0;
                    if (o_status        !== want.status)        bad = 1'b1;
                    if (o_adjacent      !== want.adjacent)      bad = 1'b1;
                    if (o_has_item      !== want.has_item)      bad = 1'b1;
                    if (o_first_vertex  !== want.first_vertex)  bad = 1'b1;
                    if (o_second_vertex !== want.second_vertex) bad = 1'b1;
                    if (o_edge_total    !== want.edge_total)    bad = 1'b1;
                    if (o_last          !== want.last)          bad = 1'b1;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"mismatch: exp st=%0d adj=%0b has=%0b %0d-%0d tot=%0d ",
                                      "last=%0b | got st=%0d adj=%0b has=%0b %0d-%0d tot=%0d ",
                                      "last=%0b"},
                                     want.status, want.adjacent, want.has_item,
                                     want.first_vertex, want.second_vertex, want.edge_total,
                                     want.last, o_status, o_adjacent, o_has_item,
                                     o_first_vertex, o_second_vertex, o_edge_total, o_last);
                    end
                end
            end
            if (out_stall_left > 0) begin
                i_out_stall    <= 1'b1;
                out_stall_left = out_stall_left - 1;
            end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
                i_out_stall    <= 1'b1;
                out_stall_left = $urandom_range(1, 6) - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // one input transfer; valid stays high on return so back-to-back items flow
    task automatic issue_action(logic [2:0] act, logic [3:0] va, logic [3:0] vb);
        if (in_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_vertex_a <= va;
        i_vertex_b <= vb;
        do @(posedge i_clk); while (o_in_stall);
        apply_graph_action(act, va, vb);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(logic [4:0] count);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        vertex_count = count;
    endtask

    function automatic logic [3:0] pick_vertex();
        int bound;
        bound = vertex_bound();
        if (bound > 0 && $urandom_range(0, 9) < 8) return 4'($urandom_range(0, bound - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic random_actions(int count);
        int         pick;
        int         idx;
        logic [3:0] va;
        logic [3:0] vb;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            va   = pick_vertex();
            vb   = pick_vertex();
            if (pick < 4) begin
                issue_action(ACT_CLEAR, va, vb);
            end else if (pick < 45) begin
                issue_action(ACT_INSERT, va, vb);
            end else if (pick < 65) begin
                // often ask about an edge that is actually stored
                if (stored_edges > 0 && $urandom_range(0, 1) == 1) begin
                    idx = $urandom_range(0, stored_edges - 1);
                    if ($urandom_range(0, 1) == 1)
                        issue_action(ACT_QUERY, log_first[idx], log_second[idx]);
                    else
                        issue_action(ACT_QUERY, log_second[idx], log_first[idx]);
                end else begin
                    issue_action(ACT_QUERY, va, vb);
                end
            end else if (pick < 80) begin
                issue_action(ACT_NBR, va, vb);
            end else if (pick < 90) begin
                issue_action(ACT_EDGES, va, vb);
            end else if (pick < 97) begin
                issue_action(ACT_INSERT, va, va);
            end else begin
                issue_action(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), va, vb);
            end
        end
    endtask

    task automatic test_basic_actions();
        issue_action(ACT_EDGES, 4'd0, 4'd0);
        issue_action(ACT_NBR, 4'd0, 4'd0);
        issue_action(ACT_QUERY, 4'd0, 4'd15);
        issue_action(ACT_INSERT, 4'd0, 4'd15);
        issue_action(ACT_INSERT, 4'd15, 4'd0);
        issue_action(ACT_INSERT, 4'd7, 4'd7);
        issue_action(ACT_INSERT, 4'd5, 4'd10);
        issue_action(ACT_INSERT, 4'd10, 4'd3);
        issue_action(ACT_QUERY, 4'd15, 4'd0);
        issue_action(ACT_QUERY, 4'd3, 4'd5);
        issue_action(ACT_NBR, 4'd10, 4'd15);
        issue_action(ACT_NBR, 4'd15, 4'd0);
        issue_action(ACT_EDGES, 4'd15, 4'd15);
        issue_action(ACT_UNUSED_LO, 4'd15, 4'd15);
        issue_action(ACT_UNUSED_MID, 4'd1, 4'd2);
        issue_action(ACT_UNUSED_HI, 4'd0, 4'd0);
        issue_action(ACT_CLEAR, 4'd15, 4'd15);
        issue_action(ACT_EDGES, 4'd0, 4'd0);
    endtask

    // edges stay stored when the vertex count shrinks below their ends
    task automatic test_vertex_limit();
        issue_action(ACT_INSERT, 4'd9, 4'd12);
        set_vertex_count(5'd4);
        issue_action(ACT_INSERT, 4'd3, 4'd4);
        issue_action(ACT_INSERT, 4'd1, 4'd3);
        issue_action(ACT_QUERY, 4'd0, 4'd5);
        issue_action(ACT_NBR, 4'd4, 4'd0);
        issue_action(ACT_NBR, 4'd3, 4'd0);
        issue_action(ACT_EDGES, 4'd0, 4'd0);
    endtask

    task automatic test_capacity();
        int         v;
        logic [3:0] va;
        set_vertex_count(5'd16);
        issue_action(ACT_CLEAR, 4'd0, 4'd0);
        for (int n = 0; n < DEF_MAX_EDGES; n++) begin
            v = $urandom_range(1, 15);
            if (n % 3 == 2) begin
                va = 4'($urandom_range(0, 15));
                issue_action(ACT_INSERT, va, 4'(va + 4'(v)));
            end else if ($urandom_range(0, 1) == 1) begin
                issue_action(ACT_INSERT, 4'd0, 4'(v));
            end else begin
                issue_action(ACT_INSERT, 4'(v), 4'd0);
            end
        end
        issue_action(ACT_INSERT, 4'd2, 4'd9);
        issue_action(ACT_INSERT, 4'd6, 4'd6);
        issue_action(ACT_NBR, 4'd0, 4'd0);
        issue_action(ACT_EDGES, 4'd0, 4'd0);
        issue_action(ACT_QUERY, 4'd0, 4'd1);
    endtask

    task automatic test_count_sweep();
        logic [4:0] counts [6];
        counts = '{5'd0, 5'd1, 5'd2, 5'd9, 5'd17, 5'd31};
        foreach (counts[i]) begin
            set_vertex_count(counts[i]);
            random_actions(6);
        end
    endtask

    task automatic test_random_traffic();
        set_vertex_count(5'd16);
        issue_action(ACT_CLEAR, 4'd0, 4'd0);
        random_actions(35);
        // hold the sender until the block has delivered everything
        wait_drained();
        random_actions(35);
    endtask

    task automatic test_full_rate();
        set_vertex_count(5'd31);
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        random_actions(15);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= 5'd0;
        i_in_valid   <= 1'b0;
        i_action     <= ACT_CLEAR;
        i_vertex_a   <= 4'd0;
        i_vertex_b   <= 4'd0;
        i_out_stall  <= 1'b0;
        cycle_count  = 0;
        mismatches   = 0;
        stored_edges = 0;
        vertex_count = 5'd16;
        in_idle_en   = 1'b1;
        out_idle_en  = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_actions();
        test_vertex_limit();
        test_capacity();
        test_count_sweep();
        test_random_traffic();
        test_full_rate();

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/uges_pkg.sv
rtl/core/uges_front.sv
rtl/core/uges_back.sv
rtl/core/undirected_graph_edge_store_top.sv
sim/tb_undirected_graph_edge_store_top.sv
